FILE: hdl/cwdn_pkg.sv
`default_nettype none

package cwdn_pkg;

   localparam int SLOTS       = 4;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ACT_W       = 3;
   localparam int NUM_DELAYS  = 4;
   localparam int ADDR_W      = 5;

   // request codes
   localparam logic [2:0] REQ_WRITE   = 3'd0;
   localparam logic [2:0] REQ_PROCESS = 3'd1;
   localparam logic [2:0] REQ_CLEAR   = 3'd2;
   localparam logic [2:0] REQ_CHECK   = 3'd3;
   localparam logic [2:0] REQ_TRIGGER = 3'd4;

   // register indexes
   localparam logic [2:0] REG_ACTIVE = 3'd0;
   localparam logic [2:0] REG_DELAY0 = 3'd1;
   localparam logic [2:0] REG_DELAY3 = 3'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [1:0]  slot_index;
      logic [31:0] new_value;
      logic [31:0] now_time;
   } req_type_type;

   typedef struct packed {
      logic        notify;
      logic [1:0]  notify_slot;
      logic [31:0] notify_value;
      logic        any_change;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/change_watch_delayed_notify.sv
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// request   | in        | req_valid / req_stall       | req_data  (cwdn_pkg::req_type_type)
// response  | out       | rsp_valid / rsp_stall       | rsp_data  (cwdn_pkg::rsp_type)
// config    | in        | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
// Write requests complete in the accept cycle. Process, clear and check walk the
// active slots one per cycle through a single compare/elapsed-time unit, then
// process and check finish with a summary step. Trigger with a valid slot index
// goes through its own step after accept. Every walk, summary and trigger step
// waits while the output register is full and stalled. Synchronous reset zeroes
// all slot state and sets active_entries to 4.

module change_watch_delayed_notify (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire cwdn_pkg::req_type_type  req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output cwdn_pkg::rsp_type            rsp_data,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [cwdn_pkg::ADDR_W-1:0]   paddr,
   input  wire [31:0]                   pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_TRIG = 2'd3;

   localparam int VW  = cwdn_pkg::VALUE_WIDTH;
   localparam int SW  = cwdn_pkg::SLOT_W;
   localparam int AW  = cwdn_pkg::ACT_W;
   localparam int NS  = cwdn_pkg::SLOTS;

   logic [1:0]       state_ff, state_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic [2:0]       op_ff, op_in;
   logic [31:0]      now_ff, now_in;
   logic             any_ff, any_in;

   logic [VW-1:0]    cur_ff   [NS];
   logic [VW-1:0]    saved_ff [NS];
   logic [31:0]      time_ff  [NS];
   logic [NS-1:0]    pend_ff;

   logic [AW-1:0]    active_ff;
   logic [31:0]      delay_ff [cwdn_pkg::NUM_DELAYS];

   logic             rsp_valid_ff, rsp_valid_in;
   cwdn_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             out_free;
   logic             cfg_wr;
   logic [2:0]       cfg_idx;
   logic [AW-1:0]    n_act;
   logic             last_slot;
   logic             idx_ok;

   // shared per-slot unit
   logic [VW-1:0]    u_cur;
   logic [31:0]      u_delay;
   logic             u_diff;
   logic             u_expired;
   logic             u_delay_nz;

   // per-step updates of the slot at cnt
   logic             wr_saved;
   logic             wr_time;
   logic             wr_pend;
   logic             pend_val;
   logic             emit;

   assign pready    = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign cfg_idx   = paddr[4:2];
   assign idx_ok    = ({1'b0, req_data.slot_index} < AW'(NS));
   assign n_act     = (active_ff > AW'(NS)) ? AW'(NS) : active_ff;
   assign last_slot = ((AW'(cnt_ff) + AW'(1)) >= n_act);

   assign u_cur      = cur_ff[cnt_ff];
   assign u_delay    = delay_ff[2'(cnt_ff)];
   assign u_diff     = (saved_ff[cnt_ff] != u_cur);
   assign u_delay_nz = (u_delay != 32'd0);
   assign u_expired  = ((now_ff - time_ff[cnt_ff]) >= u_delay);

   always_comb begin
      unique case (cfg_idx)
         3'd0:    prdata = 32'(active_ff);
         3'd1:    prdata = delay_ff[0];
         3'd2:    prdata = delay_ff[1];
         3'd3:    prdata = delay_ff[2];
         3'd4:    prdata = delay_ff[3];
         default: prdata = 32'd0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_saved     = 1'b0;
      wr_time      = 1'b0;
      wr_pend      = 1'b0;
      pend_val     = 1'b0;
      emit         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_data.req_type;
               now_in = req_data.now_time;
               any_in = 1'b0;
               cnt_in = '0;
               unique case (req_data.req_type)
                  cwdn_pkg::REQ_PROCESS,
                  cwdn_pkg::REQ_CHECK: begin
                     state_in = (n_act == '0) ? ST_SUM : ST_WALK;
                  end
                  cwdn_pkg::REQ_CLEAR: begin
                     state_in = (n_act == '0) ? ST_IDLE : ST_WALK;
                  end
                  cwdn_pkg::REQ_TRIGGER: begin
                     if (idx_ok) begin
                        cnt_in   = req_data.slot_index[SW-1:0];
                        state_in = ST_TRIG;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (out_free) begin
               unique case (op_ff)
                  cwdn_pkg::REQ_PROCESS: begin
                     if (u_diff) begin
                        wr_saved = 1'b1;
                        any_in   = 1'b1;
                        wr_pend  = 1'b1;
                        if (u_delay_nz) begin
                           wr_time  = 1'b1;
                           pend_val = 1'b1;
                        end else begin
                           emit = 1'b1;
                        end
                     end else if (pend_ff[cnt_ff] && u_expired) begin
                        wr_pend = 1'b1;
                        emit    = 1'b1;
                     end
                  end
                  cwdn_pkg::REQ_CLEAR: begin
                     if (u_diff) begin
                        wr_saved = 1'b1;
                        if (u_delay_nz) begin
                           wr_time = 1'b1;
                           wr_pend = 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (u_diff) any_in = 1'b1;
                  end
               endcase
               if (emit) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.notify         = 1'b1;
                  rsp_in.notify_slot    = 2'(cnt_ff);
                  rsp_in.notify_value   = 32'(u_cur);
                  rsp_in.any_change     = 1'b0;
                  rsp_in.last           = 1'b0;
               end
               if (last_slot) begin
                  state_in = (op_ff == cwdn_pkg::REQ_CLEAR) ? ST_IDLE : ST_SUM;
               end else begin
                  cnt_in = cnt_ff + SW'(1);
               end
            end
         end
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.notify       = 1'b0;
               rsp_in.notify_slot  = 2'd0;
               rsp_in.notify_value = 32'd0;
               rsp_in.any_change   = any_ff;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_TRIG: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.notify       = 1'b1;
               rsp_in.notify_slot  = 2'(cnt_ff);
               rsp_in.notify_value = 32'(u_cur);
               rsp_in.any_change   = 1'b0;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         op_ff        <= cwdn_pkg::REQ_WRITE;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= AW'(4);
         pend_ff      <= '0;
         for (int i = 0; i < cwdn_pkg::NUM_DELAYS; i++) delay_ff[i] <= 32'd0;
         for (int i = 0; i < NS; i++) begin
            cur_ff[i]   <= '0;
            saved_ff[i] <= '0;
            time_ff[i]  <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;

         if (cfg_wr) begin
            if (cfg_idx == cwdn_pkg::REG_ACTIVE) begin
               active_ff <= pwdata[AW-1:0];
            end else if (cfg_idx >= cwdn_pkg::REG_DELAY0 && cfg_idx <= cwdn_pkg::REG_DELAY3) begin
               delay_ff[2'(cfg_idx - cwdn_pkg::REG_DELAY0)] <= pwdata;
            end
         end

         if (accept && req_data.req_type == cwdn_pkg::REQ_WRITE && idx_ok) begin
            cur_ff[req_data.slot_index[SW-1:0]] <= VW'(req_data.new_value);
         end

         if (wr_saved) saved_ff[cnt_ff] <= u_cur;
         if (wr_time)  time_ff[cnt_ff]  <= now_ff;
         if (wr_pend)  pend_ff[cnt_ff]  <= pend_val;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire
